// ===== hdl/npes_pkg.sv =====
`timescale 1ns / 1ps

package npes_pkg;

   localparam int PORT_WIDTH          = 32;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int DIR_WIDTH           = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_START_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_START_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_END_X   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_END_Y   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_DIR     = 3'd4;

   localparam logic [DIR_WIDTH-1:0] DIR_NONE  = 3'd0;
   localparam logic [DIR_WIDTH-1:0] DIR_UP    = 3'd1;
   localparam logic [DIR_WIDTH-1:0] DIR_RIGHT = 3'd2;
   localparam logic [DIR_WIDTH-1:0] DIR_DOWN  = 3'd3;
   localparam logic [DIR_WIDTH-1:0] DIR_LEFT  = 3'd4;

endpackage

// ===== hdl/nearest_parallel_edge_search.sv =====
`timescale 1ns / 1ps
// Throughput: one vertex per cycle; the front classifies both edges of a vertex in the
// cycle it is accepted, and the back folds one queue entry per cycle into the minimum.
// A result not popped holds the back at a set's last entry, and the front stalls only
// when the queue fills behind it. The back registers the result as it pops that entry.
// Reset is synchronous and empties the queue and the result register, clears the query
// registers, the stored first and previous vertices, and drops the running best edge.

module nearest_parallel_edge_search #(
   parameter int COORD_WIDTH = npes_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = npes_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [npes_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [npes_pkg::PORT_WIDTH-1:0]             csr_data,
   input  logic                                        push,
   output logic                                        full,
   input  logic signed [npes_pkg::PORT_WIDTH-1:0]      req_vertex_x,
   input  logic signed [npes_pkg::PORT_WIDTH-1:0]      req_vertex_y,
   input  logic                                        req_polygon_first,
   input  logic                                        req_polygon_last,
   input  logic                                        req_set_last,
   output logic                                        empty,
   input  logic                                        pop,
   output logic signed [npes_pkg::PORT_WIDTH-1:0]      rsp_nearest_start_x,
   output logic signed [npes_pkg::PORT_WIDTH-1:0]      rsp_nearest_start_y,
   output logic signed [npes_pkg::PORT_WIDTH-1:0]      rsp_nearest_end_x,
   output logic signed [npes_pkg::PORT_WIDTH-1:0]      rsp_nearest_end_y,
   output logic [npes_pkg::PORT_WIDTH-1:0]             rsp_nearest_distance,
   output logic                                        rsp_found
);

   localparam int ENTRY_WIDTH = 10 * COORD_WIDTH + 3;

   logic signed [COORD_WIDTH-1:0]       q_sx_ff, q_sy_ff, q_ex_ff, q_ey_ff;
   logic [npes_pkg::DIR_WIDTH-1:0]      q_dir_ff;
   logic                                accept;
   logic [ENTRY_WIDTH-1:0]              front_entry, back_entry;
   logic                                queue_empty, queue_pop;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_sx_ff  <= '0;
         q_sy_ff  <= '0;
         q_ex_ff  <= '0;
         q_ey_ff  <= '0;
         q_dir_ff <= npes_pkg::DIR_NONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            npes_pkg::CSR_QUERY_START_X: q_sx_ff  <= csr_data[COORD_WIDTH-1:0];
            npes_pkg::CSR_QUERY_START_Y: q_sy_ff  <= csr_data[COORD_WIDTH-1:0];
            npes_pkg::CSR_QUERY_END_X:   q_ex_ff  <= csr_data[COORD_WIDTH-1:0];
            npes_pkg::CSR_QUERY_END_Y:   q_ey_ff  <= csr_data[COORD_WIDTH-1:0];
            npes_pkg::CSR_QUERY_DIR:     q_dir_ff <= csr_data[npes_pkg::DIR_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   npes_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .query_start_x   (q_sx_ff),
      .query_start_y   (q_sy_ff),
      .query_end_x     (q_ex_ff),
      .query_end_y     (q_ey_ff),
      .query_direction (q_dir_ff),
      .accept          (accept),
      .vertex_x        (req_vertex_x[COORD_WIDTH-1:0]),
      .vertex_y        (req_vertex_y[COORD_WIDTH-1:0]),
      .polygon_first   (req_polygon_first),
      .polygon_last    (req_polygon_last),
      .set_last        (req_set_last),
      .entry           (front_entry)
   );

   npes_queue #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_entry),
      .full      (full),
      .pop       (queue_pop),
      .pop_data  (back_entry),
      .empty     (queue_empty)
   );

   npes_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .query_start_x    (q_sx_ff),
      .query_start_y    (q_sy_ff),
      .query_end_x      (q_ex_ff),
      .query_end_y      (q_ey_ff),
      .entry            (back_entry),
      .entry_empty      (queue_empty),
      .entry_pop        (queue_pop),
      .pop              (pop),
      .empty            (empty),
      .nearest_start_x  (rsp_nearest_start_x),
      .nearest_start_y  (rsp_nearest_start_y),
      .nearest_end_x    (rsp_nearest_end_x),
      .nearest_end_y    (rsp_nearest_end_y),
      .nearest_distance (rsp_nearest_distance),
      .found            (rsp_found)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("Result present right after reset.");

   a_none_zero_distance: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_found) |-> (rsp_nearest_distance == '0))
      else $error("Nonzero distance on a result without a found edge.");

   a_up_beyond: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_found && (q_dir_ff == npes_pkg::DIR_UP)) |->
      (rsp_nearest_start_y > npes_pkg::PORT_WIDTH'(q_sy_ff)))
      else $error("Found edge does not lie above the query segment.");

   a_queue_pops_only_filled: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("Back end took a transaction from an empty queue.");

endmodule

// ===== hdl/npes_front.sv =====
`timescale 1ns / 1ps

module npes_front #(
   parameter int COORD_WIDTH = npes_pkg::COORD_WIDTH_DEFAULT,
   parameter int ENTRY_WIDTH = 10 * COORD_WIDTH + 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [COORD_WIDTH-1:0]        query_start_x,
   input  logic signed [COORD_WIDTH-1:0]        query_start_y,
   input  logic signed [COORD_WIDTH-1:0]        query_end_x,
   input  logic signed [COORD_WIDTH-1:0]        query_end_y,
   input  logic [npes_pkg::DIR_WIDTH-1:0]       query_direction,
   input  logic                                 accept,
   input  logic signed [COORD_WIDTH-1:0]        vertex_x,
   input  logic signed [COORD_WIDTH-1:0]        vertex_y,
   input  logic                                 polygon_first,
   input  logic                                 polygon_last,
   input  logic                                 set_last,
   output logic [ENTRY_WIDTH-1:0]               entry
);

   typedef struct packed {
      logic                          ok;
      logic [COORD_WIDTH-1:0]        distance;
      logic signed [COORD_WIDTH-1:0] sx;
      logic signed [COORD_WIDTH-1:0] sy;
      logic signed [COORD_WIDTH-1:0] ex;
      logic signed [COORD_WIDTH-1:0] ey;
   } edge_type;

   typedef struct packed {
      logic     set_last;
      edge_type main_edge;
      edge_type close_edge;
   } entry_type;

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic signed [COORD_WIDTH-1:0] close_x, close_y;
   edge_type                      main_edge, close_edge;
   entry_type                     entry_in;

   function automatic edge_type classify(
      input logic signed [COORD_WIDTH-1:0] ax,
      input logic signed [COORD_WIDTH-1:0] ay,
      input logic signed [COORD_WIDTH-1:0] bx,
      input logic signed [COORD_WIDTH-1:0] by
   );
      logic                          swap;
      logic                          horiz;
      logic signed [COORD_WIDTH-1:0] lx, ly, hx, hy;
      edge_type                      e;
      swap  = (ax > bx) || ((ax == bx) && (ay > by));
      lx    = swap ? bx : ax;
      ly    = swap ? by : ay;
      hx    = swap ? ax : bx;
      hy    = swap ? ay : by;
      horiz = (ly == hy);
      e.sx  = lx;
      e.sy  = ly;
      e.ex  = hx;
      e.ey  = hy;
      e.ok  = 1'b0;
      e.distance = '0;
      unique case (query_direction)
         npes_pkg::DIR_UP: begin
            e.ok       = horiz && (lx < query_end_x) && (query_start_x < hx) &&
                         (ly > query_start_y);
            e.distance = ly - query_start_y;
         end
         npes_pkg::DIR_DOWN: begin
            e.ok       = horiz && (lx < query_end_x) && (query_start_x < hx) &&
                         (ly < query_start_y);
            e.distance = query_start_y - ly;
         end
         npes_pkg::DIR_RIGHT: begin
            e.ok       = !horiz && (ly < query_end_y) && (query_start_y < hy) &&
                         (lx > query_start_x);
            e.distance = lx - query_start_x;
         end
         npes_pkg::DIR_LEFT: begin
            e.ok       = !horiz && (ly < query_end_y) && (query_start_y < hy) &&
                         (lx < query_start_x);
            e.distance = query_start_x - lx;
         end
         default: begin
            e.ok = 1'b0;
         end
      endcase
      return e;
   endfunction

   // A vertex that opens a polygon closes onto itself.
   assign close_x = polygon_first ? vertex_x : first_x_ff;
   assign close_y = polygon_first ? vertex_y : first_y_ff;

   always_comb begin
      main_edge           = classify(prev_x_ff, prev_y_ff, vertex_x, vertex_y);
      close_edge          = classify(vertex_x, vertex_y, close_x, close_y);
      main_edge.ok        = main_edge.ok && !polygon_first;
      close_edge.ok       = close_edge.ok && polygon_last;
      entry_in.set_last   = set_last;
      entry_in.main_edge  = main_edge;
      entry_in.close_edge = close_edge;
   end

   assign entry = entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else if (accept) begin
         if (polygon_first) begin
            first_x_ff <= vertex_x;
            first_y_ff <= vertex_y;
         end
         prev_x_ff <= vertex_x;
         prev_y_ff <= vertex_y;
      end
   end

endmodule

// ===== hdl/npes_queue.sv =====
`timescale 1ns / 1ps

module npes_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = npes_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/npes_back.sv =====
`timescale 1ns / 1ps

module npes_back #(
   parameter int COORD_WIDTH = npes_pkg::COORD_WIDTH_DEFAULT,
   parameter int ENTRY_WIDTH = 10 * COORD_WIDTH + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [COORD_WIDTH-1:0]         query_start_x,
   input  logic signed [COORD_WIDTH-1:0]         query_start_y,
   input  logic signed [COORD_WIDTH-1:0]         query_end_x,
   input  logic signed [COORD_WIDTH-1:0]         query_end_y,
   input  logic [ENTRY_WIDTH-1:0]                entry,
   input  logic                                  entry_empty,
   output logic                                  entry_pop,
   input  logic                                  pop,
   output logic                                  empty,
   output logic signed [npes_pkg::PORT_WIDTH-1:0] nearest_start_x,
   output logic signed [npes_pkg::PORT_WIDTH-1:0] nearest_start_y,
   output logic signed [npes_pkg::PORT_WIDTH-1:0] nearest_end_x,
   output logic signed [npes_pkg::PORT_WIDTH-1:0] nearest_end_y,
   output logic [npes_pkg::PORT_WIDTH-1:0]        nearest_distance,
   output logic                                  found
);

   localparam int PW = npes_pkg::PORT_WIDTH;

   typedef struct packed {
      logic                          ok;
      logic [COORD_WIDTH-1:0]        distance;
      logic signed [COORD_WIDTH-1:0] sx;
      logic signed [COORD_WIDTH-1:0] sy;
      logic signed [COORD_WIDTH-1:0] ex;
      logic signed [COORD_WIDTH-1:0] ey;
   } edge_type;

   typedef struct packed {
      logic     set_last;
      edge_type main_edge;
      edge_type close_edge;
   } entry_type;

   entry_type               cur;
   edge_type                best_ff, best_in, mid;
   logic                    best_valid_ff, best_valid_in, mid_valid, fin_valid;
   logic                    take_main, take_close, can_emit, emit;
   logic                    out_valid_ff, out_valid_in;
   logic signed [PW-1:0]    out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;
   logic signed [PW-1:0]    out_sx_in, out_sy_in, out_ex_in, out_ey_in;
   logic [PW-1:0]           out_dist_ff, out_dist_in;
   logic                    out_found_ff, out_found_in;

   assign cur       = entry;
   assign can_emit  = !out_valid_ff || pop;
   assign entry_pop = !entry_empty && (!cur.set_last || can_emit);
   assign emit      = entry_pop && cur.set_last;

   // The main edge comes before the closing edge, so it wins a tie.
   always_comb begin
      take_main  = cur.main_edge.ok &&
                   (!best_valid_ff || (cur.main_edge.distance < best_ff.distance));
      mid        = take_main ? cur.main_edge : best_ff;
      mid_valid  = best_valid_ff || take_main;
      take_close = cur.close_edge.ok &&
                   (!mid_valid || (cur.close_edge.distance < mid.distance));
      best_in    = take_close ? cur.close_edge : mid;
      fin_valid  = mid_valid || take_close;
   end

   always_comb begin
      best_valid_in = best_valid_ff;
      out_valid_in  = out_valid_ff;
      out_sx_in     = out_sx_ff;
      out_sy_in     = out_sy_ff;
      out_ex_in     = out_ex_ff;
      out_ey_in     = out_ey_ff;
      out_dist_in   = out_dist_ff;
      out_found_in  = out_found_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (entry_pop) begin
         best_valid_in = fin_valid;
      end
      if (emit) begin
         best_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_found_in  = fin_valid;
         if (fin_valid) begin
            out_sx_in   = PW'(best_in.sx);
            out_sy_in   = PW'(best_in.sy);
            out_ex_in   = PW'(best_in.ex);
            out_ey_in   = PW'(best_in.ey);
            out_dist_in = PW'(best_in.distance);
         end else begin
            out_sx_in   = PW'(query_start_x);
            out_sy_in   = PW'(query_start_y);
            out_ex_in   = PW'(query_end_x);
            out_ey_in   = PW'(query_end_y);
            out_dist_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         best_ff <= best_in;
      end
      out_sx_ff    <= out_sx_in;
      out_sy_ff    <= out_sy_in;
      out_ex_ff    <= out_ex_in;
      out_ey_ff    <= out_ey_in;
      out_dist_ff  <= out_dist_in;
      out_found_ff <= out_found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign empty            = !out_valid_ff;
   assign nearest_start_x  = out_sx_ff;
   assign nearest_start_y  = out_sy_ff;
   assign nearest_end_x    = out_ex_ff;
   assign nearest_end_y    = out_ey_ff;
   assign nearest_distance = out_dist_ff;
   assign found            = out_found_ff;

endmodule

// ===== sim/nearest_parallel_edge_search_tb.sv =====
`timescale 1ns / 1ps

module nearest_parallel_edge_search_tb;

   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 4;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_VERTICES = 1500;

   localparam logic [npes_pkg::DIR_WIDTH-1:0] DIR_RESERVED = 3'd7;

   typedef logic signed [npes_pkg::PORT_WIDTH-1:0] coord_type;

   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type COORD_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      opens;
      logic      closes;
      logic      ends_set;
   } vertex_type;

   typedef struct packed {
      coord_type                       lo_x;
      coord_type                       lo_y;
      coord_type                       hi_x;
      coord_type                       hi_y;
      logic [npes_pkg::PORT_WIDTH-1:0] gap;
      logic                            found;
   } nearest_type;

   typedef struct packed {
      coord_type                      lo_x;
      coord_type                      lo_y;
      coord_type                      hi_x;
      coord_type                      hi_y;
      logic [npes_pkg::DIR_WIDTH-1:0] dir;
   } query_type;

   typedef struct packed {
      logic        sets_query;
      query_type   query;
      vertex_type  vertex;
      logic        typed;
      nearest_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [npes_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [npes_pkg::PORT_WIDTH-1:0] csr_data = '0;
   logic push = 1'b0;
   logic full;
   coord_type req_vertex_x = '0;
   coord_type req_vertex_y = '0;
   logic req_polygon_first = 1'b0;
   logic req_polygon_last = 1'b0;
   logic req_set_last = 1'b0;
   logic empty;
   logic pop = 1'b0;
   coord_type rsp_nearest_start_x;
   coord_type rsp_nearest_start_y;
   coord_type rsp_nearest_end_x;
   coord_type rsp_nearest_end_y;
   logic [npes_pkg::PORT_WIDTH-1:0] rsp_nearest_distance;
   logic rsp_found;

   nearest_parallel_edge_search DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .push(push),
      .full(full),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_polygon_first(req_polygon_first),
      .req_polygon_last(req_polygon_last),
      .req_set_last(req_set_last),
      .empty(empty),
      .pop(pop),
      .rsp_nearest_start_x(rsp_nearest_start_x),
      .rsp_nearest_start_y(rsp_nearest_start_y),
      .rsp_nearest_end_x(rsp_nearest_end_x),
      .rsp_nearest_end_y(rsp_nearest_end_y),
      .rsp_nearest_distance(rsp_nearest_distance),
      .rsp_found(rsp_found)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   query_type      query;
   coord_type      anchor_x, anchor_y, trail_x, trail_y;
   nearest_type    best;
   logic [32:0]    best_gap;
   logic           best_found;

   nearest_type    pending_nearest[$];
   script_row_type script[$];

   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int vertices_sent = 0;
   int results_seen = 0;
   int edges_found = 0;
   int settings_written = 0;
   int idle_cycles = 0;

   coord_type frame_x = '0;
   coord_type frame_y = '0;
   int        span = 16;
   bit        wide = 1'b0;

   function automatic void clear_best();
      best = '0;
      best_gap = '1;
      best_found = 1'b0;
   endfunction

   function automatic void fold_edge(longint ax, longint ay, longint bx, longint by);
      longint t, gap, qlx, qly, qhx, qhy;
      bit hit, want_horizontal;
      qlx = $signed(query.lo_x);
      qly = $signed(query.lo_y);
      qhx = $signed(query.hi_x);
      qhy = $signed(query.hi_y);
      if (ax > bx || (ax == bx && ay > by)) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      case (query.dir)
         npes_pkg::DIR_UP, npes_pkg::DIR_DOWN: want_horizontal = 1'b1;
         npes_pkg::DIR_RIGHT, npes_pkg::DIR_LEFT: want_horizontal = 1'b0;
         default: return;
      endcase
      if ((ay == by) != want_horizontal) return;
      case (query.dir)
         npes_pkg::DIR_UP: begin
            hit = ax < qhx && qlx < bx && ay > qly;
            gap = ay - qly;
         end
         npes_pkg::DIR_DOWN: begin
            hit = ax < qhx && qlx < bx && ay < qly;
            gap = qly - ay;
         end
         npes_pkg::DIR_RIGHT: begin
            hit = ay < qhy && qly < by && ax > qlx;
            gap = ax - qlx;
         end
         default: begin
            hit = ay < qhy && qly < by && ax < qlx;
            gap = qlx - ax;
         end
      endcase
      if (hit && gap < longint'(best_gap)) begin
         best_gap = 33'(gap);
         best.lo_x = coord_type'(ax);
         best.lo_y = coord_type'(ay);
         best.hi_x = coord_type'(bx);
         best.hi_y = coord_type'(by);
         best_found = 1'b1;
      end
   endfunction

   function automatic bit take_vertex(vertex_type v, output nearest_type r);
      if (v.opens) begin
         anchor_x = v.x;
         anchor_y = v.y;
      end else begin
         fold_edge(trail_x, trail_y, $signed(v.x), $signed(v.y));
      end
      trail_x = v.x;
      trail_y = v.y;
      if (v.closes) fold_edge($signed(v.x), $signed(v.y), anchor_x, anchor_y);
      if (!v.ends_set) return 1'b0;
      if (best_found) begin
         r = best;
         r.gap = best_gap[npes_pkg::PORT_WIDTH-1:0];
         r.found = 1'b1;
      end else begin
         r.lo_x = query.lo_x;
         r.lo_y = query.lo_y;
         r.hi_x = query.hi_x;
         r.hi_y = query.hi_y;
         r.gap = '0;
         r.found = 1'b0;
      end
      clear_best();
      return 1'b1;
   endfunction

   function automatic void step(coord_type x, coord_type y, bit opens, bit closes,
                                bit ends_set);
      script_row_type row;
      row = '0;
      row.vertex = '{x, y, opens, closes, ends_set};
      script.push_back(row);
   endfunction

   function automatic void step_to(coord_type x, coord_type y, bit opens, bit closes,
                                   bit ends_set, coord_type lx, coord_type ly,
                                   coord_type hx, coord_type hy,
                                   logic [npes_pkg::PORT_WIDTH-1:0] gap, bit found);
      script_row_type row;
      row = '0;
      row.vertex = '{x, y, opens, closes, ends_set};
      row.typed = 1'b1;
      row.want = '{lx, ly, hx, hy, gap, found};
      script.push_back(row);
   endfunction

   function automatic void retarget(coord_type lx, coord_type ly, coord_type hx,
                                    coord_type hy, logic [npes_pkg::DIR_WIDTH-1:0] dir);
      script_row_type row;
      row = '0;
      row.sets_query = 1'b1;
      row.query = '{lx, ly, hx, hy, dir};
      script.push_back(row);
   endfunction

   function automatic coord_type pick(coord_type center);
      if ($urandom_range(0, 39) == 0) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      if (wide) return coord_type'($urandom());
      return center + coord_type'($urandom_range(0, 2 * span)) - coord_type'(span);
   endfunction

   function automatic query_type random_query();
      query_type q;
      coord_type a, b, level;
      span = $urandom_range(4, 64);
      wide = ($urandom_range(0, 7) == 0);
      frame_x = coord_type'($urandom()) >>> 2;
      frame_y = coord_type'($urandom()) >>> 2;
      case ($urandom_range(0, 19))
         0: q.dir = npes_pkg::DIR_NONE;
         1: q.dir = DIR_RESERVED - 3'($urandom_range(0, 2));
         2, 3, 4, 5: q.dir = npes_pkg::DIR_UP;
         6, 7, 8, 9: q.dir = npes_pkg::DIR_RIGHT;
         10, 11, 12, 13: q.dir = npes_pkg::DIR_DOWN;
         default: q.dir = npes_pkg::DIR_LEFT;
      endcase
      if (q.dir == npes_pkg::DIR_RIGHT || q.dir == npes_pkg::DIR_LEFT) begin
         level = pick(frame_x);
         a = pick(frame_y);
         b = pick(frame_y);
         q.lo_x = level;
         q.hi_x = level;
         q.lo_y = (a < b) ? a : b;
         q.hi_y = (a < b) ? b : a;
      end else begin
         level = pick(frame_y);
         a = pick(frame_x);
         b = pick(frame_x);
         q.lo_y = level;
         q.hi_y = level;
         q.lo_x = (a < b) ? a : b;
         q.hi_x = (a < b) ? b : a;
      end
      if ($urandom_range(0, 9) == 0) begin
         q.lo_x = pick(frame_x);
         q.lo_y = pick(frame_y);
         q.hi_x = pick(frame_x);
         q.hi_y = pick(frame_y);
      end
      return q;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic compare_field(string name, logic [npes_pkg::PORT_WIDTH-1:0] got,
                                logic [npes_pkg::PORT_WIDTH-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got,
                                   want));
   endtask

   task automatic check_result();
      nearest_type want;
      if (pending_nearest.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: %h %h %h %h %h %b",
                                   rsp_nearest_start_x, rsp_nearest_start_y,
                                   rsp_nearest_end_x, rsp_nearest_end_y,
                                   rsp_nearest_distance, rsp_found));
         return;
      end
      want = pending_nearest.pop_front();
      compare_field("nearest_start_x", rsp_nearest_start_x, want.lo_x);
      compare_field("nearest_start_y", rsp_nearest_start_y, want.lo_y);
      compare_field("nearest_end_x", rsp_nearest_end_x, want.hi_x);
      compare_field("nearest_end_y", rsp_nearest_end_y, want.hi_y);
      compare_field("nearest_distance", rsp_nearest_distance, want.gap);
      compare_field("found", 32'(rsp_found), 32'(want.found));
      results_seen++;
      if (want.found) edges_found++;
   endtask

   task automatic send_vertex(vertex_type v, bit typed, nearest_type want);
      nearest_type r;
      while ($urandom_range(0, 99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_vertex_x <= v.x;
      req_vertex_y <= v.y;
      req_polygon_first <= v.opens;
      req_polygon_last <= v.closes;
      req_set_last <= v.ends_set;
      @(posedge clock);
      while (full) @(posedge clock);
      vertices_sent++;
      if (take_vertex(v, r)) pending_nearest.push_back(typed ? want : r);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (pending_nearest.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [npes_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [npes_pkg::PORT_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_query(query_type q);
      write_register(npes_pkg::CSR_QUERY_START_X, q.lo_x);
      write_register(npes_pkg::CSR_QUERY_START_Y, q.lo_y);
      write_register(npes_pkg::CSR_QUERY_END_X, q.hi_x);
      write_register(npes_pkg::CSR_QUERY_END_Y, q.hi_y);
      write_register(npes_pkg::CSR_QUERY_DIR, ($urandom() & ~32'h7) | 32'(q.dir));
      csr_valid <= 1'b0;
      query = q;
      settings_written++;
   endtask

   task automatic send_random_set();
      int polygons, corners;
      coord_type x, y;
      vertex_type v;
      polygons = $urandom_range(1, 3);
      for (int p = 0; p < polygons; p++) begin
         corners = $urandom_range(1, 8);
         x = pick(frame_x);
         y = pick(frame_y);
         for (int k = 0; k < corners; k++) begin
            if (k % 2 == 1) x = pick(frame_x);
            else if (k > 0) y = pick(frame_y);
            v.x = x;
            v.y = y;
            v.opens = (k == 0);
            v.closes = (k == corners - 1);
            v.ends_set = (p == polygons - 1) && (k == corners - 1);
            if ($urandom_range(0, 9) == 0) begin
               v.opens = $urandom_range(0, 1);
               v.closes = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 59) == 0) v.ends_set = 1'b1;
            send_vertex(v, 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty) check_result();
      pop <= !reset && ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                  STALL_LIMIT, pending_nearest.size());
         $display("nearest_parallel_edge_search_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      script_row_type row;
      int sets_left;
      int phase_start;
      query = '0;
      query.dir = npes_pkg::DIR_NONE;
      anchor_x = '0;
      anchor_y = '0;
      trail_x = '0;
      trail_y = '0;
      clear_best();
      sets_left = 0;

      step_to(5, 5, 0, 1, 1, 0, 0, 0, 0, 0, 0);
      retarget(-10, 0, 10, 0, npes_pkg::DIR_UP);
      step(-5, 3, 1, 0, 0);
      step(5, 3, 0, 0, 0);
      step(5, 8, 0, 0, 0);
      step_to(-5, 8, 0, 1, 1, -5, 3, 5, 3, 3, 1);
      step(0, 4, 1, 0, 0);
      step(2, 4, 0, 0, 0);
      step(2, 6, 0, 0, 0);
      step(4, 6, 0, 0, 0);
      step(4, 4, 0, 0, 0);
      step_to(6, 4, 0, 1, 1, 0, 4, 2, 4, 4, 1);
      step(10, 2, 1, 0, 0);
      step(20, 2, 0, 0, 0);
      step(-20, 1, 0, 0, 0);
      step_to(-10, 1, 0, 1, 1, -10, 0, 10, 0, 0, 0);
      retarget(0, -5, 0, 5, npes_pkg::DIR_RIGHT);
      step(9, -3, 1, 0, 0);
      step(9, 3, 0, 0, 0);
      step(7, 3, 0, 0, 0);
      step_to(7, -3, 0, 1, 1, 7, -3, 7, 3, 7, 1);
      step_to(3, 0, 1, 1, 1, 0, -5, 0, 5, 0, 0);
      retarget(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, npes_pkg::DIR_DOWN);
      step(COORD_MAX, COORD_MIN, 1, 0, 0);
      step_to(COORD_MIN, COORD_MIN, 0, 1, 1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
              32'hffff_ffff, 1);
      retarget(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, npes_pkg::DIR_LEFT);
      step(COORD_MIN, COORD_MAX, 1, 0, 0);
      step_to(COORD_MIN, COORD_MIN, 0, 1, 1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
              32'hffff_ffff, 1);
      retarget(1, 2, 3, 4, DIR_RESERVED);
      step_to(1, 0, 1, 1, 1, 1, 2, 3, 4, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle = 6;
      recv_idle = 69;

      foreach (script[i]) begin
         row = script[i];
         if (row.sets_query) begin
            settle();
            write_query(row.query);
         end else begin
            send_vertex(row.vertex, row.typed, row.want);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 6; recv_idle = 69; end
            1: begin send_idle = 69; recv_idle = 6; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         phase_start = vertices_sent;
         while (vertices_sent - phase_start < RANDOM_VERTICES / 3) begin
            if (sets_left == 0) begin
               settle();
               write_query(random_query());
               sets_left = $urandom_range(3, 12);
            end else if ($urandom_range(0, 24) == 0) begin
               settle();
            end
            send_random_set();
            sets_left--;
         end
      end
      settle();

      $display("Run covered %0d vertices and %0d results, %0d of them with an edge found,",
               vertices_sent, results_seen, edges_found);
      $display("under %0d query settings across every direction code, with %0d mismatches.",
               settings_written, errors);
      if (errors == 0) begin
         $display("nearest_parallel_edge_search_tb: PASS");
      end else begin
         $display("nearest_parallel_edge_search_tb: FAIL");
      end
      $finish;
   end

endmodule
